### sv/fpa_pkg.sv
// Package: shared constants, codes and state type of the partition allocator.
package fpa_pkg;

  localparam int PARTITIONS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  localparam int CMD_W    = 1;
  localparam int PIDX_W   = 4;
  localparam int AMOUNT_W = 16;
  localparam int POLICY_W = 2;
  localparam int COUNT_W  = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

  localparam logic [POLICY_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] FIT_WORST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT = 1'b1;

  localparam logic [POLICY_W-1:0] RESET_POLICY = FIT_FIRST;
  localparam logic [COUNT_W-1:0]  RESET_COUNT  = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

### sv/fpa_if.sv
// Interfaces: request and result channels with valid/ready handshake.
interface fpa_req_if;
  logic                            valid;
  logic                            ready;
  logic [fpa_pkg::CMD_W-1:0]       command;
  logic [fpa_pkg::PIDX_W-1:0]      partition_index;
  logic [fpa_pkg::AMOUNT_W-1:0]    amount;

  modport source (output valid, command, partition_index, amount, input ready);
  modport sink   (input valid, command, partition_index, amount, output ready);
endinterface

interface fpa_res_if;
  logic                            valid;
  logic                            ready;
  logic                            granted;
  logic [fpa_pkg::PIDX_W-1:0]      chosen_partition;
  logic [fpa_pkg::AMOUNT_W-1:0]    remaining_size;

  modport source (output valid, granted, chosen_partition, remaining_size, input ready);
  modport sink   (input valid, granted, chosen_partition, remaining_size, output ready);
endinterface

### sv/fpa_cell.sv
// Cell: one partition's size plus one stage of the fit-search chain.
module fpa_cell #(
  parameter int INDEX     = 0,
  parameter int IDX_W     = 4,
  parameter int SIZE_BITS = fpa_pkg::SIZE_BITS_DEF
) (
  input  logic                          clk,
  input  logic [fpa_pkg::POLICY_W-1:0]  fit_policy,
  input  logic [fpa_pkg::COUNT_W-1:0]   partition_count,
  input  logic [SIZE_BITS-1:0]          req,
  input  logic                          wr_en,
  input  logic [IDX_W-1:0]              wr_idx,
  input  logic [SIZE_BITS-1:0]          wr_data,
  input  logic                          in_found,
  input  logic [IDX_W-1:0]              in_sel,
  input  logic [SIZE_BITS-1:0]          in_size,
  output logic                          out_found,
  output logic [IDX_W-1:0]              out_sel,
  output logic [SIZE_BITS-1:0]          out_size
);

  logic [SIZE_BITS-1:0] size_left;
  logic                 active;
  logic                 fits;
  logic                 take;

  assign active = int'(partition_count) > INDEX;
  assign fits   = req <= size_left;

  always_comb begin
    unique case (fit_policy)
      fpa_pkg::FIT_BEST:  take = active && fits && (!in_found || size_left < in_size);
      fpa_pkg::FIT_WORST: take = active && (!in_found || size_left > in_size);
      default:            take = active && fits && !in_found;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_idx == IDX_W'(INDEX)) begin
      size_left <= wr_data;
    end
    if (take) begin
      out_found <= 1'b1;
      out_sel   <= IDX_W'(INDEX);
      out_size  <= size_left;
    end else begin
      out_found <= in_found;
      out_sel   <= in_sel;
      out_size  <= in_size;
    end
  end

endmodule

### sv/fit_policy_partition_allocator_top.sv
// Top level: fixed-partition allocator with first/best/worst fit policy.
// Load: the result register is written directly from the request transfer.
// Allocate: the search record walks the cell chain one cell per cycle in ST_SCAN;
// ST_FINISH commits the result once the result register is free. One item at
// a time: loads one per cycle while results are taken, no request mid-allocation.
// Reset (synchronous, active high) clears control state and sets fit_policy to
// first fit and partition_count to 16; partition sizes are undefined until loaded.
module fit_policy_partition_allocator_top #(
  parameter int PARTITIONS = fpa_pkg::PARTITIONS_DEF,
  parameter int SIZE_BITS  = fpa_pkg::SIZE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  fpa_req_if.sink                        request,
  fpa_res_if.source                      result,
  input  logic                           cfg_we,
  input  logic [fpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpa_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;

  // configuration registers
  logic [fpa_pkg::POLICY_W-1:0] fit_policy;
  logic [fpa_pkg::COUNT_W-1:0]  partition_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy      <= fpa_pkg::RESET_POLICY;
      partition_count <= fpa_pkg::RESET_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fpa_pkg::CFG_FIT_POLICY: fit_policy      <= cfg_data[fpa_pkg::POLICY_W-1:0];
        fpa_pkg::CFG_PART_COUNT: partition_count <= cfg_data[fpa_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  fpa_pkg::state_t      state, state_next;
  logic [IDX_W-1:0]     scan_cnt, scan_cnt_next;
  logic [SIZE_BITS-1:0] req, req_next;

  // result register
  logic                          out_valid, out_valid_next;
  logic                          out_granted, out_granted_next;
  logic [fpa_pkg::PIDX_W-1:0]    out_part, out_part_next;
  logic [fpa_pkg::AMOUNT_W-1:0]  out_size, out_size_next;

  // broadcast write port into the cells
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [SIZE_BITS-1:0] wr_data;

  // search chain: link k feeds cell k, link PARTITIONS is the chain's output
  logic                 link_found [PARTITIONS+1];
  logic [IDX_W-1:0]     link_sel   [PARTITIONS+1];
  logic [SIZE_BITS-1:0] link_size  [PARTITIONS+1];

  assign link_found[0] = 1'b0;
  assign link_sel[0]   = '0;
  assign link_size[0]  = '0;

  for (genvar k = 0; k < PARTITIONS; k++) begin : g_cell
    fpa_cell #(
      .INDEX     (k),
      .IDX_W     (IDX_W),
      .SIZE_BITS (SIZE_BITS)
    ) u_cell (
      .clk             (clk),
      .fit_policy      (fit_policy),
      .partition_count (partition_count),
      .req             (req),
      .wr_en           (wr_en),
      .wr_idx          (wr_idx),
      .wr_data         (wr_data),
      .in_found        (link_found[k]),
      .in_sel          (link_sel[k]),
      .in_size         (link_size[k]),
      .out_found       (link_found[k+1]),
      .out_sel         (link_sel[k+1]),
      .out_size        (link_size[k+1])
    );
  end

  logic                 out_free;
  logic                 accept;
  logic [SIZE_BITS-1:0] amt;
  logic                 load_ok;
  logic                 grant;
  logic [SIZE_BITS-1:0] after_alloc;

  assign out_free = !out_valid || result.ready;
  assign request.ready = (state == fpa_pkg::ST_IDLE) && out_free;
  assign accept   = request.valid && request.ready;
  assign amt      = SIZE_BITS'(request.amount);
  assign load_ok  = int'(request.partition_index) < PARTITIONS;

  // worst fit picks the largest first and checks the fit at the end
  assign grant       = link_found[PARTITIONS] &&
                       ((fit_policy != fpa_pkg::FIT_WORST) || req <= link_size[PARTITIONS]);
  assign after_alloc = link_size[PARTITIONS] - req;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fpa_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_cnt    <= scan_cnt_next;
    req         <= req_next;
    out_granted <= out_granted_next;
    out_part    <= out_part_next;
    out_size    <= out_size_next;
  end

  always_comb begin
    state_next       = state;
    scan_cnt_next    = scan_cnt;
    req_next         = req;
    out_valid_next   = out_valid && !result.ready;
    out_granted_next = out_granted;
    out_part_next    = out_part;
    out_size_next    = out_size;
    wr_en            = 1'b0;
    wr_idx           = IDX_W'(request.partition_index);
    wr_data          = amt;

    unique case (state)
      fpa_pkg::ST_IDLE: begin
        if (accept) begin
          if (request.command == fpa_pkg::CMD_LOAD) begin
            // load finishes at once; an out-of-range index is refused
            wr_en            = load_ok;
            out_valid_next   = 1'b1;
            out_granted_next = load_ok;
            out_part_next    = load_ok ? request.partition_index : '0;
            out_size_next    = load_ok ? fpa_pkg::AMOUNT_W'(amt) : '0;
          end else begin
            req_next      = amt;
            scan_cnt_next = '0;
            state_next    = fpa_pkg::ST_SCAN;
          end
        end
      end
      fpa_pkg::ST_SCAN: begin
        scan_cnt_next = scan_cnt + 1'b1;
        if (scan_cnt == IDX_W'(PARTITIONS - 1)) begin
          state_next = fpa_pkg::ST_FINISH;
        end
      end
      fpa_pkg::ST_FINISH: begin
        // chain output is stable here; commit once the result register frees up
        wr_idx  = link_sel[PARTITIONS];
        wr_data = after_alloc;
        if (out_free) begin
          wr_en            = grant;
          out_valid_next   = 1'b1;
          out_granted_next = grant;
          out_part_next    = grant ? fpa_pkg::PIDX_W'(link_sel[PARTITIONS]) : '0;
          out_size_next    = grant ? fpa_pkg::AMOUNT_W'(after_alloc) : '0;
          state_next       = fpa_pkg::ST_IDLE;
        end
      end
      default: state_next = fpa_pkg::ST_IDLE;
    endcase
  end

  assign result.valid            = out_valid;
  assign result.granted          = out_granted;
  assign result.chosen_partition = out_part;
  assign result.remaining_size   = out_size;

endmodule

### sim/tb_top.sv
// Testbench: fit-policy partition allocator, self-checking against an inline predictor.
`timescale 1ns / 1ps

module tb_top;

  // Allocation walks every partition and writes back; this covers it with margin.
  // Used for the idle pause and the end drain.
  localparam int ALLOC_LATENCY = fpa_pkg::PARTITIONS_DEF + 2;
  localparam int SETTLE_CYCLES = ALLOC_LATENCY + 4;
  // Longest correct stretch without a transfer is about a sender gap, one
  // allocation and a receiver stall, or the idle pause before a register
  // write. Take it many times over.
  localparam int STALL_LIMIT   = 512;
  localparam int RANDOM_ITEMS  = 77;

  // Policy code three is not named in the package; it must act as first fit.
  localparam logic [fpa_pkg::POLICY_W-1:0] FIT_SPARE   = 2'd3;
  localparam logic [fpa_pkg::COUNT_W-1:0]  COUNT_NONE  = 5'd0;
  localparam logic [fpa_pkg::COUNT_W-1:0]  COUNT_ONE   = 5'd1;
  localparam logic [fpa_pkg::COUNT_W-1:0]  COUNT_FULL  = 5'd16;
  localparam logic [fpa_pkg::COUNT_W-1:0]  COUNT_OVER  = 5'd17;
  localparam logic [fpa_pkg::COUNT_W-1:0]  COUNT_TOP   = 5'd31;

  typedef struct packed {
    logic [fpa_pkg::CMD_W-1:0]    command;
    logic [fpa_pkg::PIDX_W-1:0]   index;
    logic [fpa_pkg::AMOUNT_W-1:0] amount;
  } request_t;

  typedef struct packed {
    logic                         granted;
    logic [fpa_pkg::PIDX_W-1:0]   chosen;
    logic [fpa_pkg::AMOUNT_W-1:0] left;
  } grant_t;

  logic clk = 1'b0;
  logic rst;
  logic                           cfg_we;
  logic [fpa_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fpa_pkg::CFG_DATA_W-1:0] cfg_data;

  fpa_req_if req_if ();
  fpa_res_if res_if ();

  fit_policy_partition_allocator_top u_top (
    .clk       (clk),
    .rst       (rst),
    .request   (req_if.sink),
    .result    (res_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow of the block: partition sizes and the two registers.
  logic [fpa_pkg::AMOUNT_W-1:0] part_size [fpa_pkg::PARTITIONS_DEF];
  logic [fpa_pkg::POLICY_W-1:0] cfg_policy = fpa_pkg::RESET_POLICY;
  logic [fpa_pkg::COUNT_W-1:0]  cfg_count  = fpa_pkg::RESET_COUNT;

  request_t request_q [$];   // items waiting to be driven
  grant_t   grant_q   [$];   // expected results, oldest first

  int  mismatches = 0;
  int  gap_left   = 0;       // sender idle cycles still to insert
  int  stall_left = 0;       // receiver stall cycles still to insert
  int  quiet_cycles = 0;     // watchdog: cycles since the last transfer
  bit  quiet      = 1'b0;    // final stretch: no idling on either side

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Apply one item to the shadow state and return the result it must produce.
  function automatic grant_t predict_grant(logic [fpa_pkg::CMD_W-1:0] command,
                                           logic [fpa_pkg::PIDX_W-1:0] index,
                                           logic [fpa_pkg::AMOUNT_W-1:0] amount);
    grant_t                       g;
    int                           active;
    int                           pick;
    bit                           found;
    logic [fpa_pkg::AMOUNT_W-1:0] pick_size;
    g = '0;
    if (command == fpa_pkg::CMD_LOAD) begin
      part_size[index] = amount;
      g.granted = 1'b1;
      g.chosen  = index;
      g.left    = amount;
      return g;
    end
    // Counts above the partition total saturate; zero means nothing in use.
    active    = (cfg_count > fpa_pkg::PARTITIONS_DEF) ? fpa_pkg::PARTITIONS_DEF
                                                      : int'(cfg_count);
    found     = 1'b0;
    pick      = 0;
    pick_size = '0;
    for (int i = 0; i < active; i++) begin
      case (cfg_policy)
        fpa_pkg::FIT_BEST: begin
          if (amount <= part_size[i] && (!found || part_size[i] < pick_size)) begin
            found = 1'b1; pick = i; pick_size = part_size[i];
          end
        end
        fpa_pkg::FIT_WORST: begin
          if (!found || part_size[i] > pick_size) begin
            found = 1'b1; pick = i; pick_size = part_size[i];
          end
        end
        default: begin
          // first fit, and the spare code behaves the same
          if (!found && amount <= part_size[i]) begin
            found = 1'b1; pick = i; pick_size = part_size[i];
          end
        end
      endcase
    end
    // Worst fit commits to the largest partition before checking the fit.
    if (cfg_policy == fpa_pkg::FIT_WORST && found && amount > pick_size)
      found = 1'b0;
    if (found) begin
      part_size[pick] = part_size[pick] - amount;
      g.granted = 1'b1;
      g.chosen  = fpa_pkg::PIDX_W'(pick);
      g.left    = part_size[pick];
    end
    return g;
  endfunction

  // Sizes clustered on a few values so that ties and exact fits show up.
  function automatic logic [fpa_pkg::AMOUNT_W-1:0] pick_amount();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return fpa_pkg::AMOUNT_W'(100);
      3:       return fpa_pkg::AMOUNT_W'(1000);
      4:       return fpa_pkg::AMOUNT_W'($urandom_range(1, 63));
      5:       return fpa_pkg::AMOUNT_W'($urandom_range(64, 4095));
      default: return fpa_pkg::AMOUNT_W'($urandom());
    endcase
  endfunction

  task automatic queue_item(input logic [fpa_pkg::CMD_W-1:0] command, input int index,
                            input int amount);
    request_t r;
    r.command = command;
    r.index   = fpa_pkg::PIDX_W'(index);
    r.amount  = fpa_pkg::AMOUNT_W'(amount);
    request_q.push_back(r);
  endtask

  // Mostly allocations against refreshed partitions; loads refill them with
  // full-range or clustered sizes. The index field is random for allocations
  // too, where the block must ignore it.
  task automatic queue_random(input int count);
    logic [fpa_pkg::CMD_W-1:0] command;
    int                        amount;
    for (int n = 0; n < count; n++) begin
      command = ($urandom_range(0, 9) < 3) ? fpa_pkg::CMD_LOAD : fpa_pkg::CMD_ALLOC;
      if (command == fpa_pkg::CMD_LOAD && $urandom_range(0, 1))
        amount = $urandom_range(0, 65535);
      else
        amount = int'(pick_amount());
      queue_item(command, $urandom_range(0, fpa_pkg::PARTITIONS_DEF - 1), amount);
    end
  endtask

  // Wait until nothing is queued, in flight or expected.
  task automatic wait_drained();
    while (request_q.size() != 0 || grant_q.size() != 0 || req_if.valid)
      @(posedge clk);
  endtask

  // Register writes only land while the block is idle.
  task automatic write_register(input logic [fpa_pkg::CFG_IDX_W-1:0] index,
                                input logic [fpa_pkg::CFG_DATA_W-1:0] data);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (index == fpa_pkg::CFG_FIT_POLICY)
      cfg_policy = data[fpa_pkg::POLICY_W-1:0];
    else
      cfg_count = data[fpa_pkg::COUNT_W-1:0];
  endtask

  // Request driver: holds an item until its transfer, predicts on transfer,
  // then either idles for a burst or presents the next pending item.
  always @(posedge clk) begin
    request_t nxt;
    if (rst) begin
      req_if.valid           <= 1'b0;
      req_if.command         <= fpa_pkg::CMD_LOAD;
      req_if.partition_index <= '0;
      req_if.amount          <= '0;
    end else begin
      if (req_if.valid && req_if.ready)
        grant_q.push_back(predict_grant(req_if.command, req_if.partition_index,
                                        req_if.amount));
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          nxt = request_q.pop_front();
          req_if.valid           <= 1'b1;
          req_if.command         <= nxt.command;
          req_if.partition_index <= nxt.index;
          req_if.amount          <= nxt.amount;
          if (!quiet && $urandom_range(0, 7) == 0)
            gap_left = $urandom_range(1, 7);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: every transfer is checked field by field against the
  // oldest expectation; ready drops in random bursts.
  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (grant_q.size() == 0) begin
          report($sformatf("result with nothing expected: granted %0d partition %0d size %0d",
                           res_if.granted, res_if.chosen_partition, res_if.remaining_size));
        end else begin
          want = grant_q.pop_front();
          if (res_if.granted !== want.granted)
            report($sformatf("granted: expected %0d got %0d", want.granted, res_if.granted));
          if (res_if.chosen_partition !== want.chosen)
            report($sformatf("chosen_partition: expected %0d got %0d",
                             want.chosen, res_if.chosen_partition));
          if (res_if.remaining_size !== want.left)
            report($sformatf("remaining_size: expected %0d got %0d",
                             want.left, res_if.remaining_size));
        end
      end
      if (quiet) begin
        res_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 6);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: directed opening under the reset settings, then one random
  // phase per register setting. Policies cycle through all codes; counts
  // cover one, zero, full, and values above the partition total.
  initial begin
    logic [fpa_pkg::POLICY_W-1:0] policies [12];
    logic [fpa_pkg::COUNT_W-1:0]  counts   [12];
    policies = '{fpa_pkg::FIT_BEST, fpa_pkg::FIT_WORST, FIT_SPARE, fpa_pkg::FIT_FIRST,
                 fpa_pkg::FIT_BEST, fpa_pkg::FIT_WORST, fpa_pkg::FIT_FIRST,
                 fpa_pkg::FIT_BEST, fpa_pkg::FIT_WORST, FIT_SPARE, fpa_pkg::FIT_BEST,
                 fpa_pkg::FIT_WORST};
    counts   = '{COUNT_FULL, COUNT_FULL, COUNT_FULL, COUNT_ONE, COUNT_NONE, COUNT_TOP,
                 COUNT_OVER, 5'd5, 5'd8, COUNT_FULL, 5'd2, COUNT_FULL};
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = fpa_pkg::CFG_FIT_POLICY;
    cfg_data               = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Every partition is loaded before the first allocation, so no unwritten
    // entry is ever searched. Sizes include zero, full scale and ties.
    for (int i = 0; i < fpa_pkg::PARTITIONS_DEF; i++) begin
      if (i == 1 || i == fpa_pkg::PARTITIONS_DEF - 1)
        queue_item(fpa_pkg::CMD_LOAD, i, 65535);
      else if (i == 3)
        queue_item(fpa_pkg::CMD_LOAD, i, 0);
      else if (i == 4 || i == 9)
        queue_item(fpa_pkg::CMD_LOAD, i, 300);
      else
        queue_item(fpa_pkg::CMD_LOAD, i, 100 * (i + 1));
    end
    queue_item(fpa_pkg::CMD_ALLOC, 0, 0);          // zero request still takes a partition
    queue_item(fpa_pkg::CMD_ALLOC, 7, 65535);      // full-scale request, exact fit
    queue_item(fpa_pkg::CMD_ALLOC, 0, 101);
    queue_item(fpa_pkg::CMD_ALLOC, 15, 65535);     // second full partition drained
    queue_item(fpa_pkg::CMD_ALLOC, 0, 65535);      // nothing large enough left
    queue_item(fpa_pkg::CMD_ALLOC, 15, 1);

    foreach (policies[p]) begin
      // upper data bits are don't-care for the policy register
      write_register(fpa_pkg::CFG_FIT_POLICY, {3'($urandom()), policies[p]});
      write_register(fpa_pkg::CFG_PART_COUNT, counts[p]);
      if (p == $size(policies) - 1)
        quiet = 1'b1;
      queue_random(RANDOM_ITEMS);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
